>>> rtl/ordered_stack_raise_lower_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered stack core checker
// ----------------------------------------------------------------------------
`ifndef ORDERED_STACK_RAISE_LOWER_CORE_ASSERT_SVH
`define ORDERED_STACK_RAISE_LOWER_CORE_ASSERT_SVH

// Same-cycle implication, masked while in reset.
`define OSRL_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("osrl check failed");

// Next-cycle implication, masked while in reset.
`define OSRL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("osrl check failed");

// Next-cycle implication that also holds across reset.
`define OSRL_ASSERT_NEXT_ALWAYS(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("osrl check failed");

`endif

>>> rtl/osrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osrl_pkg
// Shared types and constants for the ordered stack with raise and lower.
// ----------------------------------------------------------------------------
package osrl_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int ID_W          = 32;
  localparam int COUNT_OUT_W   = 6;

  // Command codes carried in the input word
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_RAISE  = 2'd2,
    CMD_LOWER  = 2'd3
  } cmd_t;

  // Status codes carried in the result word
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_MISSING  = 2'd1,
    STAT_IN_PLACE = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic load;    // latch compare result
    logic commit;  // perform the data move
    cmd_t op;
  } osrl_ctrl_t;

endpackage

>>> rtl/ordered_stack_raise_lower_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_stack_raise_lower_core
// Ordered stack of ids with append, remove, raise to top and lower to bottom.
// ----------------------------------------------------------------------------
//  channel  signals                               direction  word
//  in       in_valid in_ready cmd window_id       sink       command + id
//  out      out_valid out_ready status entry_count source    status + count
//
// A word is handled in two steps: the accept edge latches the id and every
// cell's compare; a later edge in S_EXEC runs the lowest-match chain through
// the cell row and shifts the slots. The result lands in an output register,
// so a new word is accepted while it waits. A stalled result holds the move step.
// Reset clears the fill count and handshake state; slot contents are not reset.
// ----------------------------------------------------------------------------
module ordered_stack_raise_lower_core #(
  parameter int DEPTH = osrl_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [osrl_pkg::ID_W-1:0]        window_id,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [osrl_pkg::COUNT_OUT_W-1:0] entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  osrl_pkg::state_t     state, state_next;
  osrl_pkg::osrl_ctrl_t ctrl;
  osrl_pkg::cmd_t       op;
  osrl_pkg::status_t    stat_next;
  logic [osrl_pkg::ID_W-1:0] id_reg;
  logic [CNT_W-1:0]     count, count_next;
  logic                 fire;

  logic [DEPTH:0]       hit;
  logic [DEPTH-1:0]     first;
  logic [DEPTH-1:0]     first_top;
  logic [osrl_pkg::ID_W-1:0] entries [DEPTH];

  // Cell row
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [osrl_pkg::ID_W-1:0] below, above;
    if (i == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign above = '0;
    end else begin : g_mid_a
      assign above = entries[i+1];
    end
    osrl_cell #(.CNT_W(CNT_W), .INDEX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .cmp_id     (window_id),
      .wr_id      (id_reg),
      .below_entry(below),
      .above_entry(above),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .first      (first[i]),
      .first_top  (first_top[i]),
      .entry      (entries[i])
    );
  end

  // Result of the pending word
  always_comb begin
    stat_next  = osrl_pkg::STAT_DONE;
    count_next = count;
    unique case (op)
      osrl_pkg::CMD_APPEND: begin
        if (count == FULL_CNT) stat_next = osrl_pkg::STAT_FULL;
        else count_next = count + CNT_W'(1);
      end
      osrl_pkg::CMD_REMOVE: begin
        if (!hit[DEPTH]) stat_next = osrl_pkg::STAT_MISSING;
        else count_next = count - CNT_W'(1);
      end
      osrl_pkg::CMD_RAISE: begin
        if (!hit[DEPTH]) stat_next = osrl_pkg::STAT_MISSING;
        else if (|first_top) stat_next = osrl_pkg::STAT_IN_PLACE;
      end
      osrl_pkg::CMD_LOWER: begin
        if (!hit[DEPTH]) stat_next = osrl_pkg::STAT_MISSING;
        else if (first[0]) stat_next = osrl_pkg::STAT_IN_PLACE;
      end
      default: ;
    endcase
  end

  // Sequencer next state and cell control
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    fire        = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.commit = 1'b0;
    ctrl.op     = op;
    unique case (state)
      osrl_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
        if (in_valid) state_next = osrl_pkg::S_EXEC;
      end
      osrl_pkg::S_EXEC: begin
        if (!out_valid || out_ready) begin
          fire        = 1'b1;
          ctrl.commit = (stat_next == osrl_pkg::STAT_DONE);
          state_next  = osrl_pkg::S_IDLE;
        end
      end
      default: state_next = osrl_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osrl_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op     <= osrl_pkg::cmd_t'(cmd);
      id_reg <= window_id;
    end
    if (fire) begin
      status      <= stat_next;
      entry_count <= osrl_pkg::COUNT_OUT_W'(count_next);
    end
  end

endmodule

>>> rtl/osrl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osrl_cell
// One stack slot: holds an id, compares it, and takes data from a neighbor or the write id.
// ----------------------------------------------------------------------------
module osrl_cell #(
  parameter int CNT_W = 6,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  osrl_pkg::osrl_ctrl_t      ctrl,
  input  logic [CNT_W-1:0]          count,
  input  logic [osrl_pkg::ID_W-1:0] cmp_id,
  input  logic [osrl_pkg::ID_W-1:0] wr_id,
  input  logic [osrl_pkg::ID_W-1:0] below_entry,
  input  logic [osrl_pkg::ID_W-1:0] above_entry,
  input  logic                      hit_in,
  output logic                      hit_out,
  output logic                      first,
  output logic                      first_top,
  output logic [osrl_pkg::ID_W-1:0] entry
);

  localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

  logic match;
  logic occupied;
  logic is_top;
  logic not_top;
  logic hit_here;

  // Slot position relative to the fill count
  assign occupied = (IDX < count);
  assign is_top   = (IDX_NEXT == count);
  assign not_top  = (IDX_NEXT < count);

  // Priority chain: hit_in means a match sits in a lower slot
  assign hit_here  = match & occupied;
  assign hit_out   = hit_in | hit_here;
  assign first     = hit_here & ~hit_in;
  assign first_top = first & is_top;

  // Compare at accept, against the incoming id
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      match <= (entry == cmp_id);
    end
  end

  // Data move on commit
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      unique case (ctrl.op)
        osrl_pkg::CMD_APPEND: begin
          if (IDX == count) entry <= wr_id;
        end
        osrl_pkg::CMD_REMOVE: begin
          if (hit_out && not_top) entry <= above_entry;
        end
        osrl_pkg::CMD_RAISE: begin
          if (hit_out && not_top) entry <= above_entry;
          else if (is_top) entry <= wr_id;
        end
        osrl_pkg::CMD_LOWER: begin
          if (INDEX == 0) entry <= wr_id;
          else if (!hit_in) entry <= below_entry;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/osrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osrl_checker
// Port-level checks on the ordered stack core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_stack_raise_lower_core_assert.svh"

module osrl_checker #(
  parameter int DEPTH = osrl_pkg::DEPTH_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       cmd,
  input logic [osrl_pkg::ID_W-1:0]        window_id,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       status,
  input logic [osrl_pkg::COUNT_OUT_W-1:0] entry_count
);

  logic unused_in;
  assign unused_in = ^{cmd, window_id};

  // A held result keeps its word
  `OSRL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(entry_count))

  // One word in flight: busy right after an accept
  `OSRL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // No result straight out of reset
  `OSRL_ASSERT_NEXT_ALWAYS(a_reset_quiet, rst, !out_valid)

  // A full report always shows the full count
  `OSRL_ASSERT_NOW(a_full_count, out_valid && status == osrl_pkg::STAT_FULL, entry_count == osrl_pkg::COUNT_OUT_W'(DEPTH))

endmodule

bind ordered_stack_raise_lower_core osrl_checker #(.DEPTH(DEPTH)) u_osrl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .cmd        (cmd),
  .window_id  (window_id),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .entry_count(entry_count)
);

>>> bench/osrl_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osrl_result_checker
// Watches both channels of the ordered stack core. It keeps its own copy of
// the id stack, works out status and count for every accepted input word, and
// compares each result word with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module osrl_result_checker #(
  parameter int DEPTH = osrl_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       cmd,
  input  logic [osrl_pkg::ID_W-1:0]        window_id,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [1:0]                       status,
  input  logic [osrl_pkg::COUNT_OUT_W-1:0] entry_count,
  output int                               errors,
  output int                               pending
);
  import osrl_pkg::*;

  typedef struct {
    status_t                st;
    logic [COUNT_OUT_W-1:0] count;
  } stack_result_t;

  // shadow stack: slot 0 is the bottom
  logic [ID_W-1:0] slots [DEPTH];
  int              fill;
  stack_result_t   expected_results [$];

  initial begin
    errors  = 0;
    pending = 0;
    fill    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  // apply one command to the shadow stack, return its status
  task automatic apply_stack_op(input cmd_t op, input logic [ID_W-1:0] id,
                                output status_t st);
    int pos;
    int i;
    pos = fill;
    // lowest match wins when the id appears more than once
    for (i = fill - 1; i >= 0; i--) begin
      if (slots[i] == id) pos = i;
    end
    st = STAT_DONE;
    if (op == CMD_APPEND) begin
      if (fill >= DEPTH) begin
        st = STAT_FULL;
      end else begin
        slots[fill] = id;
        fill++;
      end
    end else if (pos == fill) begin
      st = STAT_MISSING;
    end else begin
      case (op)
        CMD_REMOVE: begin
          for (i = pos; i < fill - 1; i++) slots[i] = slots[i + 1];
          fill--;
        end
        CMD_RAISE: begin
          if (pos == fill - 1) begin
            st = STAT_IN_PLACE;
          end else begin
            for (i = pos; i < fill - 1; i++) slots[i] = slots[i + 1];
            slots[fill - 1] = id;
          end
        end
        CMD_LOWER: begin
          if (pos == 0) begin
            st = STAT_IN_PLACE;
          end else begin
            for (i = pos; i > 0; i--) slots[i] = slots[i - 1];
            slots[0] = id;
          end
        end
      endcase
    end
  endtask

  // result side first so a word never meets its own prediction
  always @(posedge clk) begin
    stack_result_t oldest;
    status_t       st;
    if (rst) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word status=%0d count=%0d, none expected",
                                    status, entry_count));
        end else begin
          oldest = expected_results.pop_front();
          if (status !== oldest.st)
            report_mismatch($sformatf("status %0d, expected %s", status,
                                      oldest.st.name()));
          if (entry_count !== oldest.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d", entry_count,
                                      oldest.count));
        end
      end
      if (in_valid && in_ready) begin
        apply_stack_op(cmd_t'(cmd), window_id, st);
        expected_results.push_back('{st, fill[COUNT_OUT_W-1:0]});
      end
    end
    pending <= expected_results.size();
  end

endmodule

>>> bench/ordered_stack_raise_lower_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_stack_raise_lower_core_test
// Drives command words into the ordered stack core: a directed opening on
// empty stack, duplicates and end positions, then random runs whose mix of
// appends swings between filling to full and draining, across phases of
// sender gaps and receiver stalls. The checker predicts and compares.
// ----------------------------------------------------------------------------
module ordered_stack_raise_lower_core_test;
  import osrl_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 380;
  localparam int HIST_SIZE = 64;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             cmd = CMD_APPEND;
  logic [ID_W-1:0]        window_id = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] entry_count;
  int                     errors;
  int                     pending;

  // knobs shared by the sender and receiver processes
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int hold_len      = 0;
  int watchdog      = 0;

  // recently appended ids, so remove/raise/lower mostly hit
  logic [ID_W-1:0] appended_ids [HIST_SIZE];
  int              hist_n = 0;

  always #6 clk = ~clk;

  ordered_stack_raise_lower_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .window_id(window_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_count(entry_count)
  );

  osrl_result_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .window_id(window_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .entry_count(entry_count),
    .errors(errors), .pending(pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (hold_len - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: cycles in a row with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_LIMIT) begin
      $display("ordered_stack_raise_lower_core_test: errors");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  // offer one word after a random gap, hold it until accepted
  task automatic send_word(input cmd_t op, input logic [ID_W-1:0] id);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    window_id <= id;
    do @(posedge clk); while (!in_ready);
    if (op == CMD_APPEND) begin
      appended_ids[hist_n % HIST_SIZE] = id;
      hist_n++;
    end
  endtask

  // random word; append_pct steers the stack toward full or empty
  task automatic send_random(input int append_pct);
    cmd_t            op;
    logic [ID_W-1:0] id;
    int              span;
    int              r;
    r = $urandom_range(99);
    if (r < append_pct) op = CMD_APPEND;
    else op = cmd_t'($urandom_range(3, 1));
    span = (hist_n < 40) ? hist_n : 40;
    if (span > 0 && $urandom_range(99) < ((op == CMD_APPEND) ? 30 : 85))
      id = appended_ids[(hist_n - 1 - $urandom_range(span - 1)) % HIST_SIZE];
    else
      id = $urandom();
    send_word(op, id);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int idle_tab  [5];
    int stall_tab [5];
    int append_pct;
    idle_tab  = '{0, 78, 0, 38, 20};
    stall_tab = '{0, 0, 78, 38, 20};
    append_pct = 50;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack: every lookup misses
    send_word(CMD_REMOVE, 32'h1234_5678);
    send_word(CMD_RAISE,  32'h1234_5678);
    send_word(CMD_LOWER,  32'h1234_5678);
    // id extremes and a duplicate
    send_word(CMD_APPEND, 32'h0000_0000);
    send_word(CMD_APPEND, 32'hFFFF_FFFF);
    send_word(CMD_APPEND, 32'h5555_5555);
    send_word(CMD_APPEND, 32'h0000_0000);
    send_word(CMD_APPEND, 32'hAAAA_AAAA);
    // raise of the top, lower of the bottom: nothing moves
    send_word(CMD_RAISE,  32'hAAAA_AAAA);
    send_word(CMD_LOWER,  32'h0000_0000);
    // duplicate: lowest copy moves
    send_word(CMD_RAISE,  32'h0000_0000);
    send_word(CMD_LOWER,  32'hAAAA_AAAA);
    send_word(CMD_LOWER,  32'h0000_0000);
    send_word(CMD_RAISE,  32'h5555_5555);
    // removes from bottom, middle, top, and a miss
    send_word(CMD_REMOVE, 32'hAAAA_AAAA);
    send_word(CMD_REMOVE, 32'h0000_0000);
    send_word(CMD_REMOVE, 32'h5555_5555);
    send_word(CMD_REMOVE, 32'hDEAD_BEEF);
    send_word(CMD_RAISE,  32'hDEAD_BEEF);
    send_word(CMD_LOWER,  32'hDEAD_BEEF);
    send_word(CMD_REMOVE, 32'h0000_0000);
    send_word(CMD_REMOVE, 32'hFFFF_FFFF);
    wait_drained();

    // random phases with different gap and stall patterns
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = idle_tab[ph];
      stall_pct     = stall_tab[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 60 == 0) begin
          case ($urandom_range(2))
            0: append_pct = 10;
            1: append_pct = 45;
            default: append_pct = 85;
          endcase
        end
        // long receiver hold-off while words keep coming
        if ((ph == 0 || ph == 3) && n == 100) begin
          hold_len = 80;
          hold_req = 1'b1;
        end
        send_random(append_pct);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ordered_stack_raise_lower_core_test: clean");
    end else begin
      $display("ordered_stack_raise_lower_core_test: errors");
    end
    $finish;
  end

endmodule
